FILE: hw/rtl/dht_pkg.sv
package dht_pkg;

    localparam int CAPACITY  = 1024;
    localparam int NAME_LEN  = 40;

    localparam int BYTE_W    = 8;
    localparam int HANDLE_W  = 16;
    localparam int CFG_W     = 11;
    localparam int STATUS_W  = 3;
    localparam int SLOT_OUT_W = 10;
    localparam int SUM_W     = 14;

    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int SIZE_W    = $clog2(CAPACITY + 1);
    localparam int LEN_W     = $clog2(NAME_LEN + 1);
    localparam int KEY_AW    = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
    localparam int NAME_DEPTH = CAPACITY * NAME_LEN;
    localparam int NAME_AW   = $clog2(NAME_DEPTH);
    localparam int ENTRY_W   = 1 + LEN_W + HANDLE_W;
    localparam int DIV_W     = (2 * SLOT_W > SUM_W) ? 2 * SLOT_W : SUM_W;
    localparam int DCNT_W    = $clog2(DIV_W + 1);
    localparam int MIN_SIZE  = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_COLLECT,
        S_SUM_GO,
        S_SUM_WAIT,
        S_SQ_MUL,
        S_SQ_GO,
        S_SQ_WAIT,
        S_CUBE_MUL,
        S_CUBE_GO,
        S_CUBE_WAIT,
        S_SETUP,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_COPY_RD,
        S_COPY_WR,
        S_DONE
    } state_t;

endpackage

FILE: hw/rtl/dht_if.sv
interface dht_req_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [dht_pkg::BYTE_W-1:0]   name_byte;
    logic                        last_byte;
    logic [dht_pkg::HANDLE_W-1:0] record_handle;

    modport source (output valid, cmd, name_byte, last_byte, record_handle, input ready);
    modport sink   (input valid, cmd, name_byte, last_byte, record_handle, output ready);
endinterface

interface dht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dht_pkg::STATUS_W-1:0]   status;
    logic [dht_pkg::SLOT_OUT_W-1:0] slot_index;
    logic [dht_pkg::HANDLE_W-1:0]   found_handle;

    modport source (output valid, status, slot_index, found_handle, input ready);
    modport sink   (input valid, status, slot_index, found_handle, output ready);
endinterface

FILE: hw/rtl/dht_ram.sv
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/dht_mod.sv
// Restoring remainder, one dividend bit per cycle.
module dht_mod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dht_pkg::DIV_W-1:0]  dividend,
    input  logic [dht_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output logic [dht_pkg::SIZE_W-1:0] remainder
);
    import dht_pkg::*;

    logic                busy_reg, busy_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]    dvd_reg, dvd_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [SIZE_W-1:0]   dsr_reg, dsr_next;
    logic [SIZE_W:0]     trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIV_W);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
                if (trial >= {1'b0, dsr_reg})
                begin
                    rem_next = SIZE_W'(trial - {1'b0, dsr_reg});
                end
                else
                begin
                    rem_next = SIZE_W'(trial);
                end
            end
        end
    end

    assign done      = busy_reg && (cnt_reg == '0);
    assign remainder = rem_reg;
endmodule

FILE: hw/rtl/double_hash_name_table.sv
// Open-addressing name table with double hashing. A name arrives one byte per
// word on req, last_byte marking its end; cmd and record_handle are taken with
// that last word. Non-final bytes are accepted one per cycle. After the last
// byte the home slot (sum of bytes, cubed, mod table size) is formed by one
// shared bit-serial remainder unit run three times; each probe reads the slot
// entry and, if lengths match, compares name bytes one by one; an insert then
// copies its bytes one by one. One rsp word follows each last byte. After reset
// the block clears all CAPACITY slots before it takes its first byte. The user
// must write table_size via cfg_we/cfg_data while idle; the block doesn't enforce it.
module double_hash_name_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dht_pkg::CFG_W-1:0]   cfg_data,
    dht_req_if.sink                     req,
    dht_rsp_if.source                   rsp
);
    import dht_pkg::*;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    tsize_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [LEN_W-1:0]    klen_reg, klen_next;
    logic                cmd_reg, cmd_next;
    logic [HANDLE_W-1:0] hnd_reg, hnd_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SLOT_W-1:0]   r_reg, r_next;
    logic [SLOT_W-1:0]   a_reg, a_next;
    logic [2*SLOT_W-1:0] prod_reg, prod_next;
    logic [SIZE_W-1:0]   step_reg, step_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SIZE_W-1:0]   tcnt_reg, tcnt_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic [NAME_AW-1:0]  base_reg, base_next;
    status_t             st_reg, st_next;
    logic [HANDLE_W-1:0] fh_reg, fh_next;

    logic                ovld_reg, ovld_next;
    status_t             ost_reg, ost_next;
    logic [SLOT_OUT_W-1:0] oslot_reg, oslot_next;
    logic [HANDLE_W-1:0] ofh_reg, ofh_next;

    logic [SIZE_W-1:0]   size_use;
    logic                accept;

    logic                mod_start, mod_done;
    logic [DIV_W-1:0]    mod_dvd;
    logic [SIZE_W-1:0]   mod_rem;

    logic                key_we;
    logic [BYTE_W-1:0]   key_rdata;
    logic                name_we;
    logic [BYTE_W-1:0]   name_rdata;
    logic                ent_we;
    logic [SLOT_W-1:0]   ent_waddr;
    logic [ENTRY_W-1:0]  ent_wdata, ent_rdata;

    logic                ent_occ;
    logic [LEN_W-1:0]    ent_len;
    logic [HANDLE_W-1:0] ent_hnd;
    logic [SIZE_W:0]     adv_sum;
    logic [SLOT_W-1:0]   adv_slot;
    logic [SIZE_W-1:0]   tcnt_inc;

    always_comb
    begin
        if (tsize_reg < CFG_W'(MIN_SIZE))
        begin
            size_use = SIZE_W'(MIN_SIZE);
        end
        else if (tsize_reg > CFG_W'(CAPACITY))
        begin
            size_use = SIZE_W'(CAPACITY);
        end
        else
        begin
            size_use = SIZE_W'(tsize_reg);
        end
    end

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_COLLECT);

    assign ent_occ = ent_rdata[ENTRY_W-1];
    assign ent_len = ent_rdata[ENTRY_W-2 -: LEN_W];
    assign ent_hnd = ent_rdata[HANDLE_W-1:0];

    assign adv_sum  = {1'b0, SIZE_W'(slot_reg)} + {1'b0, step_reg};
    assign adv_slot = (adv_sum >= {1'b0, size_reg}) ? SLOT_W'(adv_sum - {1'b0, size_reg})
                                                     : SLOT_W'(adv_sum);
    assign tcnt_inc = tcnt_reg + 1'b1;

    dht_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dvd),
        .divisor   (size_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    dht_ram #(.WIDTH(BYTE_W), .DEPTH(NAME_LEN)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (klen_reg[KEY_AW-1:0]),
        .wdata (req.name_byte),
        .raddr (idx_reg[KEY_AW-1:0]),
        .rdata (key_rdata)
    );

    dht_ram #(.WIDTH(BYTE_W), .DEPTH(NAME_DEPTH)) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr (NAME_AW'(base_reg + NAME_AW'(idx_reg))),
        .wdata (key_rdata),
        .raddr (NAME_AW'(base_reg + NAME_AW'(idx_reg))),
        .rdata (name_rdata)
    );

    dht_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (slot_reg),
        .rdata (ent_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            tsize_reg <= CFG_W'(1021);
            sum_reg   <= '0;
            klen_reg  <= '0;
            slot_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                tsize_reg <= cfg_data;
            end
            sum_reg   <= sum_next;
            klen_reg  <= klen_next;
            slot_reg  <= slot_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        hnd_reg   <= hnd_next;
        size_reg  <= size_next;
        r_reg     <= r_next;
        a_reg     <= a_next;
        prod_reg  <= prod_next;
        step_reg  <= step_next;
        tcnt_reg  <= tcnt_next;
        idx_reg   <= idx_next;
        base_reg  <= base_next;
        st_reg    <= st_next;
        fh_reg    <= fh_next;
        ost_reg   <= ost_next;
        oslot_reg <= oslot_next;
        ofh_reg   <= ofh_next;
    end

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        klen_next  = klen_reg;
        cmd_next   = cmd_reg;
        hnd_next   = hnd_reg;
        size_next  = size_reg;
        r_next     = r_reg;
        a_next     = a_reg;
        prod_next  = prod_reg;
        step_next  = step_reg;
        slot_next  = slot_reg;
        tcnt_next  = tcnt_reg;
        idx_next   = idx_reg;
        base_next  = base_reg;
        st_next    = st_reg;
        fh_next    = fh_reg;
        ost_next   = ost_reg;
        oslot_next = oslot_reg;
        ofh_next   = ofh_reg;
        ovld_next  = ovld_reg && !rsp.ready;

        mod_start = 1'b0;
        mod_dvd   = DIV_W'(prod_reg);
        key_we    = 1'b0;
        name_we   = 1'b0;
        ent_we    = 1'b0;
        ent_waddr = slot_reg;
        ent_wdata = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ent_we = 1'b1;
                if (slot_reg == SLOT_W'(CAPACITY - 1))
                begin
                    slot_next  = '0;
                    state_next = S_COLLECT;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_COLLECT:
            begin
                if (accept)
                begin
                    if (klen_reg < LEN_W'(NAME_LEN))
                    begin
                        key_we    = 1'b1;
                        klen_next = klen_reg + 1'b1;
                        sum_next  = sum_reg + SUM_W'(req.name_byte);
                    end
                    if (req.last_byte)
                    begin
                        cmd_next   = req.cmd;
                        hnd_next   = req.record_handle;
                        size_next  = size_use;
                        state_next = S_SUM_GO;
                    end
                end
            end
            S_SUM_GO:
            begin
                mod_start  = 1'b1;
                mod_dvd    = DIV_W'(sum_reg);
                state_next = S_SUM_WAIT;
            end
            S_SUM_WAIT:
            begin
                if (mod_done)
                begin
                    r_next     = SLOT_W'(mod_rem);
                    a_next     = SLOT_W'(mod_rem);
                    state_next = S_SQ_MUL;
                end
            end
            S_SQ_MUL:
            begin
                prod_next  = a_reg * r_reg;
                state_next = S_SQ_GO;
            end
            S_SQ_GO:
            begin
                mod_start  = 1'b1;
                state_next = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (mod_done)
                begin
                    a_next     = SLOT_W'(mod_rem);
                    state_next = S_CUBE_MUL;
                end
            end
            S_CUBE_MUL:
            begin
                prod_next  = a_reg * r_reg;
                state_next = S_CUBE_GO;
            end
            S_CUBE_GO:
            begin
                mod_start  = 1'b1;
                state_next = S_CUBE_WAIT;
            end
            S_CUBE_WAIT:
            begin
                if (mod_done)
                begin
                    slot_next  = SLOT_W'(mod_rem);
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                // home < size, so home mod (size - 1) is home unless home == size - 1
                if (SIZE_W'(slot_reg) == size_reg - 1'b1)
                begin
                    step_next = SIZE_W'(1);
                end
                else
                begin
                    step_next = SIZE_W'(slot_reg) + 1'b1;
                end
                tcnt_next  = '0;
                st_next    = (cmd_reg == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                fh_next    = '0;
                state_next = S_PROBE_RD;
            end
            S_PROBE_RD:
            begin
                base_next  = NAME_AW'(slot_reg * NAME_AW'(NAME_LEN));
                idx_next   = '0;
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                if (!ent_occ)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        ent_we     = 1'b1;
                        ent_wdata  = {1'b1, klen_reg, hnd_reg};
                        st_next    = ST_INSERTED;
                        state_next = S_COPY_RD;
                    end
                    else
                    begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                end
                else if (ent_len == klen_reg)
                begin
                    state_next = S_CMP_RD;
                end
                else if (tcnt_inc == size_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    tcnt_next  = tcnt_inc;
                    slot_next  = adv_slot;
                    state_next = S_PROBE_RD;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (key_rdata != name_rdata)
                begin
                    if (tcnt_inc == size_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        tcnt_next  = tcnt_inc;
                        slot_next  = adv_slot;
                        state_next = S_PROBE_RD;
                    end
                end
                else if (idx_reg + 1'b1 == klen_reg)
                begin
                    st_next    = (cmd_reg == CMD_INSERT) ? ST_DUPLICATE : ST_FOUND;
                    fh_next    = ent_hnd;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                name_we = 1'b1;
                if (idx_reg + 1'b1 == klen_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_COPY_RD;
                end
            end
            S_DONE:
            begin
                if (!ovld_reg || rsp.ready)
                begin
                    ovld_next  = 1'b1;
                    ost_next   = st_reg;
                    oslot_next = SLOT_OUT_W'(slot_reg);
                    ofh_next   = fh_reg;
                    sum_next   = '0;
                    klen_next  = '0;
                    state_next = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    assign rsp.valid        = ovld_reg;
    assign rsp.status       = ost_reg;
    assign rsp.slot_index   = oslot_reg;
    assign rsp.found_handle = ofh_reg;
endmodule
